>>> hdl/wssf_pkg.sv
// ----------------------------------------------------------------------------
// wssf_pkg
// Types and constants shared by the wheel speed / stall fallback block.
// ----------------------------------------------------------------------------
package wssf_pkg;

  localparam int WHEELS = 4;

  localparam int DELTA_W = 16;
  localparam int CMD_W   = 16;
  localparam int SPEED_W = 22;
  localparam int COUNT_W = 5;
  localparam int SCALE_W = 20;
  localparam int EPS_W   = 16;
  localparam int TRIG_W  = 15;
  localparam int LIMIT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // product of |delta| and scale, rounding offset, quotient shift
  localparam int PROD_W    = DELTA_W + 1 + SCALE_W;
  localparam int ROUND_SH  = 12;
  localparam int QUOT_W    = PROD_W - ROUND_SH;

  localparam logic [SCALE_W-1:0] RPM_SCALE_RST       = 20'd160627;
  localparam logic [EPS_W-1:0]   SPEED_EPSILON_RST   = 16'd40;
  localparam logic [TRIG_W-1:0]  COMMAND_TRIGGER_RST = 15'd2000;
  localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST      = 5'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RPM_SCALE       = 2'd0,
    CFG_SPEED_EPSILON   = 2'd1,
    CFG_COMMAND_TRIGGER = 2'd2,
    CFG_FAIL_LIMIT      = 2'd3
  } cfg_idx_t;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [WHEELS-1:0]         wheel_mask_t;

endpackage

>>> hdl/wheel_speed_stall_fallback.sv
// ----------------------------------------------------------------------------
// wheel_speed_stall_fallback
// Four-wheel speed from encoder tick deltas, stall (no-feedback) detection
// and copy-from-healthy-wheel fallback for faulted wheels.
//
// Channels: in_* carries one control period (deltas, commands, read-valid and
// fault masks); out_* returns four speeds in 1/16 rpm and the no-feedback
// mask, one result beat per input beat. cfg_* writes the four settings by
// index and is always ready; write it only while the block is idle.
//
// Throughput: one beat per cycle while the receiver takes each result. The
// input register feeds one pass of multiply, round, saturate, stall check and
// fallback into the result register; the stored speeds and stall counters
// update on the same edge.
// Reset: settings return to their defaults, stored speeds and counters clear,
// both stages empty. When the receiver stalls, the result holds, the input
// register fills, and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module wheel_speed_stall_fallback (
  input  logic                                      clk,
  input  logic                                      rst_n,

  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [wssf_pkg::DELTA_W-1:0]       in_delta_fl,
  input  logic signed [wssf_pkg::DELTA_W-1:0]       in_delta_fr,
  input  logic signed [wssf_pkg::DELTA_W-1:0]       in_delta_rl,
  input  logic signed [wssf_pkg::DELTA_W-1:0]       in_delta_rr,
  input  logic signed [wssf_pkg::CMD_W-1:0]         in_cmd_fl,
  input  logic signed [wssf_pkg::CMD_W-1:0]         in_cmd_fr,
  input  logic signed [wssf_pkg::CMD_W-1:0]         in_cmd_rl,
  input  logic signed [wssf_pkg::CMD_W-1:0]         in_cmd_rr,
  input  logic [wssf_pkg::WHEELS-1:0]               in_read_ok_mask,
  input  logic [wssf_pkg::WHEELS-1:0]               in_fault_mask,

  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [wssf_pkg::SPEED_W-1:0]       out_rpm_fl,
  output logic signed [wssf_pkg::SPEED_W-1:0]       out_rpm_fr,
  output logic signed [wssf_pkg::SPEED_W-1:0]       out_rpm_rl,
  output logic signed [wssf_pkg::SPEED_W-1:0]       out_rpm_rr,
  output logic [wssf_pkg::WHEELS-1:0]               out_no_feedback_mask,

  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [wssf_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [wssf_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int W = wssf_pkg::WHEELS;

  // settings
  logic [wssf_pkg::SCALE_W-1:0] rpm_scale_r;
  logic [wssf_pkg::EPS_W-1:0]   speed_epsilon_r;
  logic [wssf_pkg::TRIG_W-1:0]  command_trigger_r;
  logic [wssf_pkg::LIMIT_W-1:0] fail_limit_r;

  // input register
  logic                                 s1_valid_r;
  logic signed [wssf_pkg::DELTA_W-1:0]  delta_r [W];
  logic signed [wssf_pkg::CMD_W-1:0]    cmd_r   [W];
  wssf_pkg::wheel_mask_t                ok_r;
  wssf_pkg::wheel_mask_t                fm_r;

  // state
  wssf_pkg::speed_t speed_r [W];
  wssf_pkg::count_t count_r [W];

  // result register
  logic                  out_valid_r;
  wssf_pkg::speed_t      rpm_r [W];
  wssf_pkg::wheel_mask_t nf_r;

  // per-period datapath
  wssf_pkg::speed_t      spd   [W];
  wssf_pkg::speed_t      fb    [W];
  wssf_pkg::count_t      count_nxt [W];
  wssf_pkg::wheel_mask_t nf_nxt;

  logic in_fire;
  logic adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ---- settings ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_scale_r       <= wssf_pkg::RPM_SCALE_RST;
      speed_epsilon_r   <= wssf_pkg::SPEED_EPSILON_RST;
      command_trigger_r <= wssf_pkg::COMMAND_TRIGGER_RST;
      fail_limit_r      <= wssf_pkg::FAIL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wssf_pkg::cfg_idx_t'(cfg_index))
        wssf_pkg::CFG_RPM_SCALE:       rpm_scale_r       <= cfg_data[wssf_pkg::SCALE_W-1:0];
        wssf_pkg::CFG_SPEED_EPSILON:   speed_epsilon_r   <= cfg_data[wssf_pkg::EPS_W-1:0];
        wssf_pkg::CFG_COMMAND_TRIGGER: command_trigger_r <= cfg_data[wssf_pkg::TRIG_W-1:0];
        wssf_pkg::CFG_FAIL_LIMIT:      fail_limit_r      <= cfg_data[wssf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- input register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta_r[0] <= in_delta_fl;
      delta_r[1] <= in_delta_fr;
      delta_r[2] <= in_delta_rl;
      delta_r[3] <= in_delta_rr;
      cmd_r[0]   <= in_cmd_fl;
      cmd_r[1]   <= in_cmd_fr;
      cmd_r[2]   <= in_cmd_rl;
      cmd_r[3]   <= in_cmd_rr;
      ok_r       <= in_read_ok_mask;
      fm_r       <= in_fault_mask;
    end
  end

  // ---- speed and stall check, per wheel ----
  always_comb begin
    logic [wssf_pkg::DELTA_W:0]   d17;
    logic [wssf_pkg::DELTA_W:0]   mag;
    logic [wssf_pkg::PROD_W-1:0]  prod;
    logic [wssf_pkg::QUOT_W-1:0]  q;
    logic [wssf_pkg::SPEED_W:0]   qn;
    logic [wssf_pkg::SPEED_W-1:0] s_abs;
    logic [wssf_pkg::CMD_W-1:0]   c_abs;
    logic                         hi_cmd;
    logic                         lo_cmd;
    logic                         still;
    logic                         at_lim;
    d17 = '0; mag = '0; prod = '0; q = '0; qn = '0; s_abs = '0; c_abs = '0;
    hi_cmd = 1'b0; lo_cmd = 1'b0; still = 1'b0; at_lim = 1'b0;
    nf_nxt = '0;
    for (int w = 0; w < W; w++) begin
      d17  = {delta_r[w][wssf_pkg::DELTA_W-1], delta_r[w]};
      mag  = d17[wssf_pkg::DELTA_W] ? (~d17 + 1'b1) : d17;
      prod = wssf_pkg::PROD_W'(mag) * wssf_pkg::PROD_W'(rpm_scale_r)
             + wssf_pkg::PROD_W'(1 << (wssf_pkg::ROUND_SH - 1));
      q    = prod[wssf_pkg::PROD_W-1:wssf_pkg::ROUND_SH];
      if (d17[wssf_pkg::DELTA_W]) begin
        qn = (q > wssf_pkg::QUOT_W'(2097152)) ? (wssf_pkg::SPEED_W+1)'(2097152)
                                               : q[wssf_pkg::SPEED_W:0];
        qn = ~qn + 1'b1;
        spd[w] = wssf_pkg::speed_t'(qn[wssf_pkg::SPEED_W-1:0]);
      end else begin
        spd[w] = (q > wssf_pkg::QUOT_W'(2097151)) ? wssf_pkg::speed_t'(2097151)
                                                   : wssf_pkg::speed_t'(q[wssf_pkg::SPEED_W-1:0]);
      end
      s_abs  = spd[w][wssf_pkg::SPEED_W-1] ? (~spd[w] + 1'b1) : spd[w];
      c_abs  = cmd_r[w][wssf_pkg::CMD_W-1] ? (~cmd_r[w] + 1'b1) : cmd_r[w];
      hi_cmd = c_abs > {1'b0, command_trigger_r};
      lo_cmd = c_abs < {1'b0, command_trigger_r};
      still  = s_abs < wssf_pkg::SPEED_W'(speed_epsilon_r);
      at_lim = count_r[w] >= fail_limit_r;

      if (!ok_r[w]) begin
        spd[w]       = speed_r[w];
        count_nxt[w] = count_r[w];
        nf_nxt[w]    = 1'b1;
      end else if (at_lim && lo_cmd) begin
        count_nxt[w] = count_r[w];
        nf_nxt[w]    = 1'b1;
      end else begin
        if (hi_cmd && still) begin
          count_nxt[w] = at_lim ? count_r[w] : count_r[w] + 1'b1;
        end else begin
          count_nxt[w] = '0;
        end
        nf_nxt[w] = count_nxt[w] >= fail_limit_r;
      end
    end
  end

  // ---- fallback from healthy wheels ----
  always_comb begin
    for (int w = 0; w < W; w++) begin
      fb[w] = spd[w];
    end
    unique case (fm_r)
      4'b0001: fb[0] = spd[2];
      4'b0010: fb[1] = spd[3];
      4'b0100: fb[2] = spd[0];
      4'b1000: fb[3] = spd[1];
      4'b0101: begin fb[0] = spd[1]; fb[2] = spd[3]; end
      4'b1010: begin fb[1] = spd[0]; fb[3] = spd[2]; end
      4'b1100: begin fb[2] = spd[0]; fb[3] = spd[1]; end
      4'b0011: begin fb[0] = spd[2]; fb[1] = spd[3]; end
      4'b1001: begin fb[0] = spd[2]; fb[3] = spd[1]; end
      4'b0110: begin fb[1] = spd[3]; fb[2] = spd[0]; end
      4'b1110: begin
        for (int w = 0; w < W; w++) fb[w] = spd[0];
      end
      4'b1101: begin
        for (int w = 0; w < W; w++) fb[w] = spd[1];
      end
      4'b1011: begin
        for (int w = 0; w < W; w++) fb[w] = spd[2];
      end
      4'b0111: begin
        for (int w = 0; w < W; w++) fb[w] = spd[3];
      end
      default: ;
    endcase
  end

  // ---- state and result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < W; w++) begin
        speed_r[w] <= '0;
        count_r[w] <= '0;
      end
    end else if (adv) begin
      for (int w = 0; w < W; w++) begin
        speed_r[w] <= fb[w];
        count_r[w] <= count_nxt[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int w = 0; w < W; w++) begin
        rpm_r[w] <= fb[w];
      end
      nf_r <= nf_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rpm_fl           = rpm_r[0];
  assign out_rpm_fr           = rpm_r[1];
  assign out_rpm_rl           = rpm_r[2];
  assign out_rpm_rr           = rpm_r[3];
  assign out_no_feedback_mask = nf_r;

endmodule
